// File: hdl/tksd_pkg.sv
// ----------------------------------------------------------------------------
// tksd_pkg: shared types and constants of the terminal key sequence decoder
// Key kind codes, modifier codes, parse phase codes and byte values
// ----------------------------------------------------------------------------
package tksd_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [3:0] t_kind;
    typedef logic [2:0] t_mod;
    typedef logic [2:0] t_phase;
    typedef logic [3:0] t_fkey;

    // key kinds
    localparam t_kind KIND_ENDREAD = 4'd0;
    localparam t_kind KIND_ENTER   = 4'd1;
    localparam t_kind KIND_BKSP    = 4'd2;
    localparam t_kind KIND_PRINT   = 4'd3;
    localparam t_kind KIND_CTRL    = 4'd4;
    localparam t_kind KIND_ESCAPE  = 4'd5;
    localparam t_kind KIND_UP      = 4'd6;
    localparam t_kind KIND_HOME    = 4'd10;
    localparam t_kind KIND_DELETE  = 4'd11;
    localparam t_kind KIND_END     = 4'd12;
    localparam t_kind KIND_FUNC    = 4'd13;

    // modifiers
    localparam t_mod MOD_NONE      = 3'd0;
    localparam t_mod MOD_CTRL_SHFT = 3'd5;

    // parse phases
    localparam t_phase PH_IDLE = 3'd0;
    localparam t_phase PH_ESC  = 3'd1;
    localparam t_phase PH_BRK  = 3'd2;
    localparam t_phase PH_B3   = 3'd3;
    localparam t_phase PH_B4   = 3'd4;
    localparam t_phase PH_B5   = 3'd5;
    localparam t_phase PH_B6   = 3'd6;

    // byte values
    localparam t_byte CH_BS     = 8'd8;
    localparam t_byte CH_LF     = 8'd10;
    localparam t_byte CH_ESC    = 8'd27;
    localparam t_byte CH_LBRK   = 8'd91;
    localparam t_byte CH_TILDE  = 8'd126;
    localparam t_byte CH_SEMI   = 8'd59;
    localparam t_byte CH_UPA    = 8'd65;
    localparam t_byte CH_DNA    = 8'd68;
    localparam t_byte CH_ONE    = 8'd49;
    localparam t_byte CH_TWO    = 8'd50;
    localparam t_byte CH_THREE  = 8'd51;
    localparam t_byte CH_FOUR   = 8'd52;
    localparam t_byte CH_SIX    = 8'd54;
    localparam t_byte CTRL_BASE = 8'd96;
    localparam t_byte EOR_RESET = 8'd122;

    localparam t_fkey FKEY_MAX  = 4'd12;

    // function key number from the two code digits, 0 when not a function key
    function automatic t_fkey fkey_number(input t_byte a, input t_byte b);
        t_fkey n;
        n = 4'd0;
        if (a == CH_ONE) begin
            if (b >= 8'd49 && b <= 8'd53) n = 4'(b - 8'd48);
            else if (b >= 8'd55 && b <= 8'd57) n = 4'(b - 8'd49);
        end else if (a == CH_TWO) begin
            case (b)
                8'd48:   n = 4'd9;
                8'd49:   n = 4'd10;
                8'd51:   n = 4'd11;
                8'd52:   n = 4'd12;
                default: n = 4'd0;
            endcase
        end
        return n;
    endfunction

endpackage

// File: hdl/tksd_if.sv
// ----------------------------------------------------------------------------
// tksd_if: channel interfaces of the terminal key sequence decoder
// Raw key byte channel and decoded key event channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface tksd_key_if;
    import tksd_pkg::*;
    logic  valid;
    logic  ready;
    t_byte key_byte;
    logic  more_pending;

    modport source (output valid, output key_byte, output more_pending, input ready);
    modport sink   (input valid, input key_byte, input more_pending, output ready);
endinterface

interface tksd_evt_if;
    import tksd_pkg::*;
    logic  valid;
    logic  ready;
    t_kind key_kind;
    t_byte key_char;
    t_mod  modifier;

    modport source (output valid, output key_kind, output key_char, output modifier,
                    input ready);
    modport sink   (input valid, input key_kind, input key_char, input modifier,
                    output ready);
endinterface

// File: hdl/terminal_key_sequence_decoder.sv
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder: raw terminal bytes to key events
// Decodes single bytes and VT100/xterm escape sequences into key events
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle. Each accepted byte is decoded against the
// parse phase and the stored sequence bytes by short logic. The phase and the
// store are loaded on the accepting edge; any key event is loaded into the
// output register, or into the skid register behind it while an event waits
// there, so the block can take one more byte while an event waits. Input
// ready drops only while the skid register holds an event. Bytes that give no
// event (sequence bytes, dropped bytes) never fill the output stages. The
// end-of-read byte is written through i_cfg_we/i_cfg_wdata and resets to 'z';
// the user must write it while the block is idle; the block does not check.
module terminal_key_sequence_decoder
    import tksd_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  t_byte          i_cfg_wdata,
    tksd_key_if.sink       i_key,
    tksd_evt_if.source     o_evt
);

    typedef struct packed {
        t_kind kind;
        t_byte ch;
        t_mod  md;
    } t_evt;

    // configuration and parse state
    t_byte  r_eor;
    t_phase r_phase, n_phase;
    t_byte  r_b3, n_b3, r_b4, n_b4, r_b5, n_b5, r_b6, n_b6;

    // output and skid registers
    logic r_out_valid, r_skid_valid;
    t_evt r_out, r_skid;

    // decode results
    logic   res_v;
    t_evt   res;
    t_fkey  fk;
    t_byte  b;
    logic   in_fire, out_fire;

    assign b        = i_key.key_byte;
    assign in_fire  = i_key.valid && i_key.ready;
    assign out_fire = r_out_valid && o_evt.ready;
    assign fk       = fkey_number(r_b3, r_b4);

    // byte decode against the current phase
    always_comb begin
        n_phase = PH_IDLE;
        n_b3    = r_b3;
        n_b4    = r_b4;
        n_b5    = r_b5;
        n_b6    = r_b6;
        res_v   = 1'b0;
        res     = '{kind: KIND_ENDREAD, ch: 8'd0, md: MOD_NONE};
        case (r_phase)
            PH_ESC: begin
                if (b == CH_LBRK) n_phase = PH_BRK;
            end
            PH_BRK: begin
                if (b inside {[CH_UPA:CH_DNA]}) begin
                    res_v    = 1'b1;
                    res.kind = KIND_UP + 4'(b - CH_UPA);
                end else begin
                    n_b3    = b;
                    n_phase = PH_B3;
                end
            end
            PH_B3: begin
                if (b == CH_TILDE) begin
                    res_v = (r_b3 == CH_ONE) || (r_b3 == CH_THREE) || (r_b3 == CH_FOUR);
                    if (r_b3 == CH_ONE) res.kind = KIND_HOME;
                    else if (r_b3 == CH_THREE) res.kind = KIND_DELETE;
                    else res.kind = KIND_END;
                end else begin
                    n_b4    = b;
                    n_phase = PH_B4;
                end
            end
            PH_B4: begin
                if (b == CH_TILDE) begin
                    res_v    = (fk != 4'd0);
                    res.kind = KIND_FUNC;
                    res.ch   = {4'd0, fk};
                end else begin
                    n_b5    = b;
                    n_phase = PH_B5;
                end
            end
            PH_B5: begin
                if (b != CH_TILDE) begin
                    n_b6    = b;
                    n_phase = PH_B6;
                end
            end
            PH_B6: begin
                res_v    = (b == CH_TILDE) && (fk != 4'd0) && (r_b5 == CH_SEMI)
                           && (r_b6 inside {[CH_TWO:CH_SIX]});
                res.kind = KIND_FUNC;
                res.ch   = {4'd0, fk};
                res.md   = 3'(r_b6 - CH_ONE);
            end
            default: begin
                // idle: classify a single byte
                res_v = 1'b1;
                if (b == r_eor) res.kind = KIND_ENDREAD;
                else if (b == CH_BS) res.kind = KIND_BKSP;
                else if (b == CH_LF) res.kind = KIND_ENTER;
                else if (b inside {[8'd32:8'd126]}) begin
                    res.kind = KIND_PRINT;
                    res.ch   = b;
                end else if (b inside {[8'd1:8'd26]}) begin
                    res.kind = KIND_CTRL;
                    res.ch   = CTRL_BASE + b;
                end else if (b == CH_ESC && !i_key.more_pending) begin
                    res.kind = KIND_ESCAPE;
                end else begin
                    res_v = 1'b0;
                    if (b == CH_ESC) n_phase = PH_ESC;
                end
            end
        endcase
    end

    // configuration register and parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eor   <= EOR_RESET;
            r_phase <= PH_IDLE;
            r_b3    <= 8'd0;
            r_b4    <= 8'd0;
            r_b5    <= 8'd0;
            r_b6    <= 8'd0;
        end else begin
            if (i_cfg_we) r_eor <= i_cfg_wdata;
            if (in_fire) begin
                r_phase <= n_phase;
                r_b3    <= n_b3;
                r_b4    <= n_b4;
                r_b5    <= n_b5;
                r_b6    <= n_b6;
            end
        end
    end

    // output register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_fire) begin
            r_out_valid <= in_fire && res_v;
        end else if (in_fire && res_v) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) r_out <= r_skid;
        end else if (!r_out_valid || out_fire) begin
            r_out <= res;
        end else begin
            r_skid <= res;
        end
    end

    assign i_key.ready    = !r_skid_valid;
    assign o_evt.valid    = r_out_valid;
    assign o_evt.key_kind = r_out.kind;
    assign o_evt.key_char = r_out.ch;
    assign o_evt.modifier = r_out.md;

endmodule

// File: hdl/tksd_checker.sv
// ----------------------------------------------------------------------------
// tksd_checker: port checks of the terminal key sequence decoder
// Watches the key event channel and flags illegal events over time
// ----------------------------------------------------------------------------
module tksd_checker
    import tksd_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_valid,
    input logic  i_ready,
    input t_kind i_kind,
    input t_byte i_char,
    input t_mod  i_mod
);

    // no event right after reset
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("event valid after reset");

    // a stalled event holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_kind) && $stable(i_char)
        && $stable(i_mod))
        else $error("stalled event changed");

    // only function keys carry a modifier
    a_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_mod != MOD_NONE |-> i_kind == KIND_FUNC && i_mod <= MOD_CTRL_SHFT)
        else $error("bad modifier");

    // function key number in range
    a_fkey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_kind == KIND_FUNC |-> i_char != 8'd0 && i_char <= {4'd0, FKEY_MAX})
        else $error("bad function key number");

    // kind code in range
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_kind <= KIND_FUNC)
        else $error("bad key kind");

endmodule

bind terminal_key_sequence_decoder tksd_checker u_tksd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_evt.valid),
    .i_ready (o_evt.ready),
    .i_kind  (o_evt.key_kind),
    .i_char  (o_evt.key_char),
    .i_mod   (o_evt.modifier)
);
